// ----- hdl/mtq_pkg.sv -----
// Shared types and constants for the matrix-to-quaternion decomposition pipeline.
`default_nettype none

package mtq_pkg;

    // Unit value in Q2.30
    localparam logic [31:0] ONE_Q30 = 32'h4000_0000;
    // Largest value a scale output can show
    localparam logic [30:0] SCALE_MAX = 31'h7FFF_FFFF;
    // APB register map
    localparam logic ADDR_MIN_SCALE = 1'b0;

    // One matrix transfer, Q8.24 entries
    typedef struct packed {
        logic signed [31:0] in_r0c0;
        logic signed [31:0] in_r0c1;
        logic signed [31:0] in_r0c2;
        logic signed [31:0] in_r1c0;
        logic signed [31:0] in_r1c1;
        logic signed [31:0] in_r1c2;
        logic signed [31:0] in_r2c0;
        logic signed [31:0] in_r2c1;
        logic signed [31:0] in_r2c2;
    } mat_item_t;

    // One result transfer
    typedef struct packed {
        logic signed [31:0] quat_w;
        logic signed [31:0] quat_x;
        logic signed [31:0] quat_y;
        logic signed [31:0] quat_z;
        logic [30:0]        scale_x;
        logic [30:0]        scale_y;
        logic [30:0]        scale_z;
        logic               degenerate;
    } quat_item_t;

    // Quaternion branch, picked by trace or largest diagonal entry
    typedef enum logic [1:0] {
        BR_W = 2'd0,
        BR_X = 2'd1,
        BR_Y = 2'd2,
        BR_Z = 2'd3
    } branch_t;

    // Scale and degenerate status riding along with the rotation math
    typedef struct packed {
        logic [2:0][30:0] scale;
        logic             degen;
    } scl_tag_t;

    // Sideband through the norm square root
    typedef struct packed {
        logic [3:0][31:0] v;
        scl_tag_t         s;
    } vec_tag_t;

    // Sideband through the final divide
    typedef struct packed {
        scl_tag_t s;
        logic     zero_norm;
    } nrm_tag_t;

endpackage

`default_nettype wire

// ----- hdl/mtq_isqrt.sv -----
// Pipelined 64-bit floor square root, one result bit per stage, several lanes.
`default_nettype none

module mtq_isqrt
    import mtq_pkg::*;
#(
    parameter int LANES = 1,
    parameter int TAG_W = 1
)
(
    input  wire logic                    clk,
    input  wire logic                    rst_n,
    input  wire logic                    en,
    input  wire logic                    in_vld,
    input  wire logic [LANES-1:0][63:0]  rad,
    input  wire logic [TAG_W-1:0]        in_tag,
    output logic                         out_vld,
    output logic [LANES-1:0][31:0]       root,
    output logic [TAG_W-1:0]             out_tag
);

    localparam int STEPS = 32;

    logic [STEPS:1]                vld_reg;
    logic [LANES-1:0][63:0]        rem_reg [1:STEPS];
    logic [LANES-1:0][63:0]        res_reg [1:STEPS];
    logic [TAG_W-1:0]              tag_reg [1:STEPS];

    for (genvar k = 0; k < STEPS; k++) begin : g_step
        localparam logic [63:0] BIT = 64'd1 << (62 - 2 * k);
        logic                   vld_in;
        logic [LANES-1:0][63:0] rem_in;
        logic [LANES-1:0][63:0] res_in;
        logic [TAG_W-1:0]       tag_in;
        logic [LANES-1:0][63:0] rem_next;
        logic [LANES-1:0][63:0] res_next;

        if (k == 0) begin : g_first
            assign vld_in = in_vld;
            assign rem_in = rad;
            assign res_in = '0;
            assign tag_in = in_tag;
        end
        else begin : g_rest
            assign vld_in = vld_reg[k];
            assign rem_in = rem_reg[k];
            assign res_in = res_reg[k];
            assign tag_in = tag_reg[k];
        end

        // One restoring root step per lane
        always_comb
        begin
            for (int l = 0; l < LANES; l++)
            begin
                if (rem_in[l] >= res_in[l] + BIT)
                begin
                    rem_next[l] = rem_in[l] - (res_in[l] + BIT);
                    res_next[l] = (res_in[l] >> 1) + BIT;
                end
                else
                begin
                    rem_next[l] = rem_in[l];
                    res_next[l] = res_in[l] >> 1;
                end
            end
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
                vld_reg[k+1] <= 1'b0;
            else if (en)
                vld_reg[k+1] <= vld_in;
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                rem_reg[k+1] <= rem_next;
                res_reg[k+1] <= res_next;
                tag_reg[k+1] <= tag_in;
            end
        end
    end

    // Root fits in 32 bits
    always_comb
    begin
        for (int l = 0; l < LANES; l++)
            root[l] = res_reg[STEPS][l][31:0];
    end

    assign out_vld = vld_reg[STEPS];
    assign out_tag = tag_reg[STEPS];

endmodule

`default_nettype wire

// ----- hdl/mtq_div.sv -----
// Pipelined signed Q30 divider, (mag << 30) / den, one quotient bit per stage.
`default_nettype none

module mtq_div
    import mtq_pkg::*;
#(
    parameter int LANES = 1,
    parameter int TAG_W = 1
)
(
    input  wire logic                    clk,
    input  wire logic                    rst_n,
    input  wire logic                    en,
    input  wire logic                    in_vld,
    input  wire logic [LANES-1:0][31:0]  num_mag,
    input  wire logic [LANES-1:0]        num_neg,
    input  wire logic [LANES-1:0][31:0]  den,
    input  wire logic [TAG_W-1:0]        in_tag,
    output logic                         out_vld,
    output logic [LANES-1:0][31:0]       quo,
    output logic [TAG_W-1:0]             out_tag
);

    // Numerator never exceeds the divisor, so the quotient needs 31 bits
    localparam int STEPS = 31;

    logic [STEPS:1]                vld_reg;
    logic [LANES-1:0][31:0]        rem_reg [1:STEPS];
    logic [LANES-1:0][30:0]        q_reg   [1:STEPS];
    logic [LANES-1:0][31:0]        den_reg [1:STEPS];
    logic [LANES-1:0]              neg_reg [1:STEPS];
    logic [TAG_W-1:0]              tag_reg [1:STEPS];

    logic                          out_vld_reg;
    logic [LANES-1:0][31:0]        quo_reg;
    logic [LANES-1:0][31:0]        quo_next;
    logic [TAG_W-1:0]              out_tag_reg;

    for (genvar k = 0; k < STEPS; k++) begin : g_step
        logic                   vld_in;
        logic [LANES-1:0][31:0] rem_in;
        logic [LANES-1:0]       sh_in;
        logic [LANES-1:0][30:0] q_in;
        logic [LANES-1:0][31:0] den_in;
        logic [LANES-1:0]       neg_in;
        logic [TAG_W-1:0]       tag_in;
        logic [LANES-1:0][31:0] rem_next;
        logic [LANES-1:0][30:0] q_next;

        if (k == 0) begin : g_first
            // Dividend top bits start the remainder, its low bit shifts in first
            always_comb
            begin
                for (int l = 0; l < LANES; l++)
                begin
                    rem_in[l] = {1'b0, num_mag[l][31:1]};
                    sh_in[l]  = num_mag[l][0];
                end
            end
            assign vld_in = in_vld;
            assign q_in   = '0;
            assign den_in = den;
            assign neg_in = num_neg;
            assign tag_in = in_tag;
        end
        else begin : g_rest
            assign vld_in = vld_reg[k];
            assign rem_in = rem_reg[k];
            assign sh_in  = '0;
            assign q_in   = q_reg[k];
            assign den_in = den_reg[k];
            assign neg_in = neg_reg[k];
            assign tag_in = tag_reg[k];
        end

        // Restoring divide step per lane
        always_comb
        begin
            for (int l = 0; l < LANES; l++)
            begin
                if ({rem_in[l], sh_in[l]} >= {1'b0, den_in[l]})
                begin
                    rem_next[l] = 32'({rem_in[l], sh_in[l]} - {1'b0, den_in[l]});
                    q_next[l]   = {q_in[l][29:0], 1'b1};
                end
                else
                begin
                    rem_next[l] = {rem_in[l][30:0], sh_in[l]};
                    q_next[l]   = {q_in[l][29:0], 1'b0};
                end
            end
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
                vld_reg[k+1] <= 1'b0;
            else if (en)
                vld_reg[k+1] <= vld_in;
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                rem_reg[k+1] <= rem_next;
                q_reg[k+1]   <= q_next;
                den_reg[k+1] <= den_in;
                neg_reg[k+1] <= neg_in;
                tag_reg[k+1] <= tag_in;
            end
        end
    end

    // Clamp to one and apply the sign
    always_comb
    begin
        for (int l = 0; l < LANES; l++)
        begin
            logic [31:0] q;
            q = {1'b0, q_reg[STEPS][l]};
            if (q > ONE_Q30)
                q = ONE_Q30;
            quo_next[l] = neg_reg[STEPS][l] ? (~q + 32'd1) : q;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_vld_reg <= 1'b0;
        else if (en)
            out_vld_reg <= vld_reg[STEPS];
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            quo_reg     <= quo_next;
            out_tag_reg <= tag_reg[STEPS];
        end
    end

    assign out_vld = out_vld_reg;
    assign quo     = quo_reg;
    assign out_tag = out_tag_reg;

endmodule

`default_nettype wire

// ----- hdl/mtq_quat.sv -----
// Branch select, unnormalized quaternion terms and their squared norm, five stages.
`default_nettype none

module mtq_quat
    import mtq_pkg::*;
(
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             en,
    input  wire logic             in_vld,
    input  wire logic [8:0][31:0] r,
    input  wire scl_tag_t         in_tag,
    output logic                  out_vld,
    output logic [3:0][31:0]      v,
    output logic [63:0]           n2,
    output scl_tag_t              out_tag
);

    localparam logic signed [34:0] ONE_35 = 35'sd1 <<< 30;

    logic [5:1]       vld_reg;
    scl_tag_t         tag_reg [1:5];

    // Stage 1: trace test and diagonal compares
    logic [8:0][31:0] r1_reg;
    branch_t          br_reg;
    branch_t          br_next;
    logic signed [33:0] tr;

    always_comb
    begin
        tr = 34'($signed(r[0])) + 34'($signed(r[4])) + 34'($signed(r[8]));
        if (tr > 34'sd0)
            br_next = BR_W;
        else if ($signed(r[0]) > $signed(r[4]) && $signed(r[0]) > $signed(r[8]))
            br_next = BR_X;
        else if ($signed(r[4]) > $signed(r[8]))
            br_next = BR_Y;
        else
            br_next = BR_Z;
    end

    // Stage 2: quaternion terms for the chosen branch
    logic signed [34:0] v2_reg [0:3];
    logic signed [34:0] v2_next [0:3];
    logic signed [34:0] e [0:8];

    always_comb
    begin
        for (int i = 0; i < 9; i++)
            e[i] = 35'($signed(r1_reg[i]));
        case (br_reg)
            BR_W:
            begin
                v2_next[0] = ONE_35 + e[0] + e[4] + e[8];
                v2_next[1] = e[7] - e[5];
                v2_next[2] = e[2] - e[6];
                v2_next[3] = e[3] - e[1];
            end
            BR_X:
            begin
                v2_next[0] = e[7] - e[5];
                v2_next[1] = ONE_35 + e[0] - e[4] - e[8];
                v2_next[2] = e[1] + e[3];
                v2_next[3] = e[2] + e[6];
            end
            BR_Y:
            begin
                v2_next[0] = e[2] - e[6];
                v2_next[1] = e[1] + e[3];
                v2_next[2] = ONE_35 + e[4] - e[0] - e[8];
                v2_next[3] = e[5] + e[7];
            end
            default:
            begin
                v2_next[0] = e[3] - e[1];
                v2_next[1] = e[2] + e[6];
                v2_next[2] = e[5] + e[7];
                v2_next[3] = ONE_35 + e[8] - e[0] - e[4];
            end
        endcase
    end

    // Stage 3: divide by four toward zero, take magnitudes
    logic [3:0][31:0] v3_reg;
    logic [3:0][31:0] v3_next;
    logic [3:0][30:0] mag3_reg;
    logic [3:0][30:0] mag3_next;

    always_comb
    begin
        for (int i = 0; i < 4; i++)
        begin
            logic signed [34:0] adj;
            logic signed [34:0] q;
            logic signed [34:0] a;
            adj = v2_reg[i] + (v2_reg[i][34] ? 35'sd3 : 35'sd0);
            q   = adj >>> 2;
            a   = q[34] ? -q : q;
            v3_next[i]   = q[31:0];
            mag3_next[i] = a[30:0];
        end
    end

    // Stage 4: squares
    logic [3:0][31:0] v4_reg;
    logic [3:0][61:0] sq4_reg;

    // Stage 5: sum of squares
    logic [3:0][31:0] v5_reg;
    logic [63:0]      n2_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld_reg <= '0;
        else if (en)
            vld_reg <= {vld_reg[4:1], in_vld};
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            r1_reg     <= r;
            br_reg     <= br_next;
            tag_reg[1] <= in_tag;
            for (int i = 0; i < 4; i++)
                v2_reg[i] <= v2_next[i];
            tag_reg[2] <= tag_reg[1];
            v3_reg     <= v3_next;
            mag3_reg   <= mag3_next;
            tag_reg[3] <= tag_reg[2];
            v4_reg     <= v3_reg;
            for (int i = 0; i < 4; i++)
                sq4_reg[i] <= 62'(mag3_reg[i]) * 62'(mag3_reg[i]);
            tag_reg[4] <= tag_reg[3];
            v5_reg     <= v4_reg;
            n2_reg     <= 64'(sq4_reg[0]) + 64'(sq4_reg[1])
                        + 64'(sq4_reg[2]) + 64'(sq4_reg[3]);
            tag_reg[5] <= tag_reg[4];
        end
    end

    assign out_vld = vld_reg[5];
    assign v       = v5_reg;
    assign n2      = n2_reg;
    assign out_tag = tag_reg[5];

endmodule

`default_nettype wire

// ----- hdl/matrix_to_quaternion_decompose.sv -----
// Top level: rotation quaternion and column scales of a 3x3 Q8.24 matrix.
//
// The mat channel carries one 3x3 matrix per transfer; the quat channel returns
// one result per matrix in order: a unit quaternion in Q2.30, the three column
// lengths (saturated) and a degenerate flag. Both channels use valid/stall.
// The user must write the min_scale threshold over the APB port only while the block
// is idle; the block itself does not enforce this. Between an accepted matrix and
// its result on quat lie three stages for squares and column sums, 32 per square
// root, 32 per Q30 divide (two of each), five for the quaternion terms and norm,
// and one output register. Matrices are taken at one transfer per clock while
// mat_stall is low. The whole pipeline advances together. When quat is stalled
// while holding a result, one more result drops into a skid register, and
// mat_stall rises only while that skid register is full. No result is lost or
// repeated. Reset clears all valid bits and loads min_scale with round(1e-6) in
// the input format; results in flight are dropped.
`default_nettype none

module matrix_to_quaternion_decompose
    import mtq_pkg::*;
#(
    parameter int IN_FRAC_BITS = 24
)
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        mat_valid,
    output logic             mat_stall,
    input  wire mat_item_t   mat,
    output logic             quat_valid,
    input  wire logic        quat_stall,
    output quat_item_t       quat,
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic        paddr,
    input  wire logic [31:0] pwdata,
    output logic [31:0]      prdata,
    output logic             pready
);

    localparam logic [24:0] MIN_SCALE_RST =
        25'(((64'd1 << IN_FRAC_BITS) + 64'd500000) / 64'd1000000);

    // Configuration register
    logic [24:0] min_scale_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            min_scale_reg <= MIN_SCALE_RST;
        else if (psel && penable && pwrite && paddr == ADDR_MIN_SCALE)
            min_scale_reg <= pwdata[24:0];
    end

    assign pready = 1'b1;
    assign prdata = (paddr == ADDR_MIN_SCALE) ? {7'd0, min_scale_reg} : 32'd0;

    // Global advance: held only while the skid register is occupied
    logic skid_valid_reg;
    logic pipe_en;

    assign pipe_en   = !skid_valid_reg;
    assign mat_stall = skid_valid_reg;

    logic [8:0][31:0] m_in;
    assign m_in = {mat.in_r2c2, mat.in_r2c1, mat.in_r2c0,
                   mat.in_r1c2, mat.in_r1c1, mat.in_r1c0,
                   mat.in_r0c2, mat.in_r0c1, mat.in_r0c0};

    // Stage A: register entries and magnitudes
    logic             a_vld_reg;
    logic [8:0][31:0] a_m_reg;
    logic [8:0][31:0] a_mag_reg;
    logic [8:0][31:0] a_mag_next;

    always_comb
    begin
        for (int i = 0; i < 9; i++)
            a_mag_next[i] = m_in[i][31] ? (~m_in[i] + 32'd1) : m_in[i];
    end

    // Stage B: squares; stage C: column sums
    logic             b_vld_reg;
    logic [8:0][31:0] b_m_reg;
    logic [8:0][63:0] b_sq_reg;
    logic             c_vld_reg;
    logic [8:0][31:0] c_m_reg;
    logic [2:0][63:0] c_sum_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_vld_reg <= 1'b0;
            b_vld_reg <= 1'b0;
            c_vld_reg <= 1'b0;
        end
        else if (pipe_en)
        begin
            a_vld_reg <= mat_valid;
            b_vld_reg <= a_vld_reg;
            c_vld_reg <= b_vld_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (pipe_en)
        begin
            a_m_reg   <= m_in;
            a_mag_reg <= a_mag_next;
            b_m_reg   <= a_m_reg;
            for (int i = 0; i < 9; i++)
                b_sq_reg[i] <= 64'(a_mag_reg[i]) * 64'(a_mag_reg[i]);
            c_m_reg <= b_m_reg;
            for (int j = 0; j < 3; j++)
                c_sum_reg[j] <= b_sq_reg[j] + b_sq_reg[3 + j] + b_sq_reg[6 + j];
        end
    end

    // Column lengths
    logic             s1_vld;
    logic [2:0][31:0] len;
    logic [8:0][31:0] s1_m;

    mtq_isqrt #(
        .LANES (3),
        .TAG_W (288)
    ) u_len_sqrt (
        .clk     (clk),
        .rst_n   (rst_n),
        .en      (pipe_en),
        .in_vld  (c_vld_reg),
        .rad     (c_sum_reg),
        .in_tag  (c_m_reg),
        .out_vld (s1_vld),
        .root    (len),
        .out_tag (s1_m)
    );

    // Threshold test, saturated scales, divider operands
    scl_tag_t         s1_tag;
    logic [8:0][31:0] d1_mag;
    logic [8:0]       d1_neg;
    logic [8:0][31:0] d1_den;

    always_comb
    begin
        s1_tag.degen = 1'b0;
        for (int j = 0; j < 3; j++)
        begin
            if (len[j] == 32'd0 || len[j] < {7'd0, min_scale_reg})
                s1_tag.degen = 1'b1;
            s1_tag.scale[j] = len[j][31] ? SCALE_MAX : len[j][30:0];
        end
        for (int i = 0; i < 9; i++)
        begin
            d1_neg[i] = s1_m[i][31];
            d1_mag[i] = s1_m[i][31] ? (~s1_m[i] + 32'd1) : s1_m[i];
            d1_den[i] = len[i % 3];
        end
    end

    // Normalized rotation entries
    logic             r_vld;
    logic [8:0][31:0] r;
    scl_tag_t         r_tag;

    mtq_div #(
        .LANES (9),
        .TAG_W ($bits(scl_tag_t))
    ) u_rot_div (
        .clk     (clk),
        .rst_n   (rst_n),
        .en      (pipe_en),
        .in_vld  (s1_vld),
        .num_mag (d1_mag),
        .num_neg (d1_neg),
        .den     (d1_den),
        .in_tag  (s1_tag),
        .out_vld (r_vld),
        .quo     (r),
        .out_tag (r_tag)
    );

    // Quaternion terms and squared norm
    logic             q_vld;
    logic [3:0][31:0] v;
    logic [63:0]      n2;
    scl_tag_t         q_tag;
    vec_tag_t         q_vtag;

    mtq_quat u_quat (
        .clk     (clk),
        .rst_n   (rst_n),
        .en      (pipe_en),
        .in_vld  (r_vld),
        .r       (r),
        .in_tag  (r_tag),
        .out_vld (q_vld),
        .v       (v),
        .n2      (n2),
        .out_tag (q_tag)
    );

    assign q_vtag.v = v;
    assign q_vtag.s = q_tag;

    // Norm
    logic             s2_vld;
    logic [0:0][31:0] norm;
    vec_tag_t         s2_tag;

    mtq_isqrt #(
        .LANES (1),
        .TAG_W ($bits(vec_tag_t))
    ) u_norm_sqrt (
        .clk     (clk),
        .rst_n   (rst_n),
        .en      (pipe_en),
        .in_vld  (q_vld),
        .rad     (n2),
        .in_tag  (q_vtag),
        .out_vld (s2_vld),
        .root    (norm),
        .out_tag (s2_tag)
    );

    nrm_tag_t         n_tag;
    logic [3:0][31:0] d2_mag;
    logic [3:0]       d2_neg;
    logic [3:0][31:0] d2_den;

    always_comb
    begin
        n_tag.s         = s2_tag.s;
        n_tag.zero_norm = (norm[0] == 32'd0);
        for (int i = 0; i < 4; i++)
        begin
            d2_neg[i] = s2_tag.v[i][31];
            d2_mag[i] = s2_tag.v[i][31] ? (~s2_tag.v[i] + 32'd1) : s2_tag.v[i];
            d2_den[i] = norm[0];
        end
    end

    // Unit quaternion
    logic             f_vld;
    logic [3:0][31:0] f_q;
    nrm_tag_t         f_tag;

    mtq_div #(
        .LANES (4),
        .TAG_W ($bits(nrm_tag_t))
    ) u_norm_div (
        .clk     (clk),
        .rst_n   (rst_n),
        .en      (pipe_en),
        .in_vld  (s2_vld),
        .num_mag (d2_mag),
        .num_neg (d2_neg),
        .den     (d2_den),
        .in_tag  (n_tag),
        .out_vld (f_vld),
        .quo     (f_q),
        .out_tag (f_tag)
    );

    // Identity for degenerate input or zero norm
    quat_item_t last_item;

    always_comb
    begin
        if (f_tag.s.degen || f_tag.zero_norm)
        begin
            last_item.quat_w = ONE_Q30;
            last_item.quat_x = '0;
            last_item.quat_y = '0;
            last_item.quat_z = '0;
        end
        else
        begin
            last_item.quat_w = f_q[0];
            last_item.quat_x = f_q[1];
            last_item.quat_y = f_q[2];
            last_item.quat_z = f_q[3];
        end
        last_item.scale_x    = f_tag.s.scale[0];
        last_item.scale_y    = f_tag.s.scale[1];
        last_item.scale_z    = f_tag.s.scale[2];
        last_item.degenerate = f_tag.s.degen;
    end

    // Output register with one skid entry
    logic       out_valid_reg;
    quat_item_t out_item_reg;
    quat_item_t skid_item_reg;
    logic       out_take;

    assign out_take = out_valid_reg && !quat_stall;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else if (skid_valid_reg)
        begin
            if (out_take)
                skid_valid_reg <= 1'b0;
        end
        else if (f_vld)
        begin
            if (!out_valid_reg || out_take)
                out_valid_reg <= 1'b1;
            else
                skid_valid_reg <= 1'b1;
        end
        else if (out_take)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (skid_valid_reg)
        begin
            if (out_take)
                out_item_reg <= skid_item_reg;
        end
        else if (f_vld)
        begin
            if (!out_valid_reg || out_take)
                out_item_reg <= last_item;
            else
                skid_item_reg <= last_item;
        end
    end

    assign quat_valid = out_valid_reg;
    assign quat       = out_item_reg;

    // Skid entry only exists behind a held output
    a_skid_behind_out: assert property (@(posedge clk) disable iff (!rst_n)
        skid_valid_reg |-> out_valid_reg)
        else $error("skid occupied without a pending output");

    // Skid fills only when the output was stalled
    a_skid_fill: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(skid_valid_reg) |-> $past(out_valid_reg && quat_stall))
        else $error("skid filled while output was free");

    // Degenerate results carry the identity quaternion
    a_degen_identity: assert property (@(posedge clk) disable iff (!rst_n)
        (quat_valid && quat.degenerate) |->
            (quat.quat_w == $signed(ONE_Q30) && quat.quat_x == 32'sd0
             && quat.quat_y == 32'sd0 && quat.quat_z == 32'sd0))
        else $error("degenerate result without identity quaternion");

    // The w component of the quaternion stays within unit range
    a_unit_range: assert property (@(posedge clk) disable iff (!rst_n)
        quat_valid |-> (quat.quat_w <= $signed(ONE_Q30)
                        && quat.quat_w >= -$signed(ONE_Q30)))
        else $error("quat_w out of range");

endmodule

`default_nettype wire
